### rtl/prdg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prdg_pkg
// Shared constants, register indexes and types of the ray direction generator.
// ----------------------------------------------------------------------------
package prdg_pkg;

  // Default parameter values
  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 16;

  // Register widths
  localparam int HEIGHT_W   = 13;
  localparam int STEP_W     = 31;
  localparam int CORNER_W   = 32;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;

  // The largest normalized magnitude lies in [2^(NORM_W-1), 2^NORM_W)
  localparam int NORM_W = 30;
  localparam int SUM_W  = 2 * NORM_W + 2;
  localparam int ROOT_W = SUM_W / 2;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_HEIGHT    = 3'd0,
    REG_STEP_X          = 3'd1,
    REG_STEP_Y          = 3'd2,
    REG_CORNER_X        = 3'd3,
    REG_CORNER_Y        = 3'd4,
    REG_CAMERA_DISTANCE = 3'd5
  } cfg_idx_e;

  // Per-item flags that ride along the pipeline
  typedef struct packed {
    logic nx;    // x component negative
    logic ny;    // y component negative
    logic zero;  // whole vector is zero
  } side_t;

endpackage : prdg_pkg
`default_nettype wire

### rtl/prdg_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prdg_isqrt
// Pipelined integer square root, one root bit per stage, floor result.
// A tag and a valid bit travel alongside each operand.
// ----------------------------------------------------------------------------
module prdg_isqrt #(
  parameter int TW = 1
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        en_i,
  input  wire logic                        vld_i,
  input  wire logic [prdg_pkg::SUM_W-1:0]  s_i,
  input  wire logic [TW-1:0]               tag_i,
  output logic                             vld_o,
  output logic [prdg_pkg::ROOT_W-1:0]      root_o,
  output logic [TW-1:0]                    tag_o
);
  import prdg_pkg::*;

  localparam int RB = ROOT_W;
  localparam int IW = SUM_W + 2;

  logic [SUM_W-1:0] rem_q  [RB-1];
  logic [RB-1:0]    root_q [RB];
  logic [TW-1:0]    tag_q  [RB];
  logic [RB-1:0]    vld_q;

  for (genvar i = 0; i < RB; i++) begin : g_stage
    localparam int K = RB - 1 - i;
    logic [SUM_W-1:0] rem_in;
    logic [RB-1:0]    root_in;
    logic [TW-1:0]    tag_in;
    logic             vld_in;
    logic [IW-1:0]    inc;
    logic             take;

    if (i == 0) begin : g_first
      assign rem_in  = s_i;
      assign root_in = '0;
      assign tag_in  = tag_i;
      assign vld_in  = vld_i;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign tag_in  = tag_q[i-1];
      assign vld_in  = vld_q[i-1];
    end

    // (root + 2^k)^2 - root^2
    assign inc  = (IW'(root_in) << (K + 1)) + (IW'(1) << (2 * K));
    assign take = IW'(rem_in) >= inc;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[i] <= take ? (root_in | (RB'(1) << K)) : root_in;
        tag_q[i]  <= tag_in;
      end
    end

    if (i < RB - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[i] <= take ? SUM_W'(IW'(rem_in) - inc) : rem_in;
        end
      end
    end
  end

  assign vld_o  = vld_q[RB-1];
  assign root_o = root_q[RB-1];
  assign tag_o  = tag_q[RB-1];

endmodule : prdg_isqrt
`default_nettype wire

### rtl/prdg_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prdg_div
// Pipelined restoring divider, one quotient bit per stage. Gives
// (a * 2^(FRAC_BITS+1) + r) div 2r, the rounded unit component.
// ----------------------------------------------------------------------------
module prdg_div #(
  parameter int FRAC_BITS = prdg_pkg::FRAC_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        en_i,
  input  wire logic [prdg_pkg::NORM_W-1:0] a_i,
  input  wire logic [prdg_pkg::ROOT_W-1:0] r_i,
  output logic [FRAC_BITS:0]               q_o
);
  import prdg_pkg::*;

  localparam int QB = FRAC_BITS + 1;
  localparam int DW = ROOT_W + 1;
  localparam int NW = DW + FRAC_BITS;

  logic [NW-1:0] rem_q [QB-1];
  logic [DW-1:0] d_q   [QB-1];
  logic [QB-1:0] q_q   [QB];

  for (genvar i = 0; i < QB; i++) begin : g_stage
    localparam int K = QB - 1 - i;
    logic [NW-1:0] rem_in;
    logic [DW-1:0] d_in;
    logic [QB-1:0] q_in;
    logic [NW-1:0] dsh;
    logic          take;

    if (i == 0) begin : g_first
      assign rem_in = (NW'(a_i) << (FRAC_BITS + 1)) + NW'(r_i);
      assign d_in   = {r_i, 1'b0};
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign d_in   = d_q[i-1];
      assign q_in   = q_q[i-1];
    end

    assign dsh  = NW'(d_in) << K;
    assign take = rem_in >= dsh;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        q_q[i] <= {q_in[QB-2:0], take};
      end
    end

    if (i < QB - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[i] <= take ? (rem_in - dsh) : rem_in;
          d_q[i]   <= d_in;
        end
      end
    end
  end

  assign q_o = q_q[QB-1];

endmodule : prdg_div
`default_nettype wire

### rtl/pinhole_ray_direction_generator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pinhole_ray_direction_generator
// Turns a pixel (column, row) into the unit direction of its primary ray.
//
//   channel  | dir | handshake              | contents
//   s_axis   | in  | tvalid/tready          | pixel_col, pixel_row
//   m_axis   | out | tvalid/tready          | dir_x, dir_y, dir_z
//   cfg      | in  | cfg_we_i (no ready)    | cfg_idx_i, cfg_data_i
//
// One word per cycle sustained while the output is not stalled. The path is 8 set-up
// and normalize stages, 31 square root stages, FRAC_BITS + 1 divider stages
// and the output register. The square root pipeline sets the depth.
// Reset loads the config register defaults and clears all valid bits; no clearing pass.
// A stall at the output freezes the whole pipeline in place.
// ----------------------------------------------------------------------------
module pinhole_ray_direction_generator #(
  parameter int COORD_BITS = prdg_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = prdg_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  // config write port
  input  wire logic                                    cfg_we_i,
  input  wire logic [prdg_pkg::CFG_IDX_W-1:0]          cfg_idx_i,
  input  wire logic [prdg_pkg::CFG_DATA_W-1:0]         cfg_data_i,
  // pixel input
  input  wire logic                                    s_axis_tvalid,
  output logic                                         s_axis_tready,
  // pixel_col, pixel_row (lowest first), zero padded
  input  wire logic [((2*COORD_BITS+7)/8)*8-1:0]       s_axis_tdata,
  // direction output
  output logic                                         m_axis_tvalid,
  input  wire logic                                    m_axis_tready,
  // dir_x, dir_y, dir_z (lowest first), zero padded
  output logic [((3*FRAC_BITS+5+7)/8)*8-1:0]           m_axis_tdata
);
  import prdg_pkg::*;

  localparam int XY_W   = FRAC_BITS + 2;
  localparam int Z_W    = FRAC_BITS + 1;
  localparam int OUT_W  = ((2 * XY_W + Z_W + 7) / 8) * 8;
  localparam int FLW    = ((COORD_BITS > HEIGHT_W) ? COORD_BITS : HEIGHT_W) + 2;
  localparam int OXW    = COORD_BITS + 1;
  localparam int OYW    = FLW + 1;
  localparam int PXW    = STEP_W + OXW;
  localparam int PYW    = STEP_W + 1 + OYW;
  localparam int VW     = PYW + 1;
  localparam int NG     = (VW + 7) / 8;
  localparam int GW     = $clog2(NG);
  localparam int PW     = GW + 3;
  localparam int TARGET = NORM_W - 1;
  localparam int SW     = $bits(side_t);
  localparam int TW     = 3 * NORM_W + SW;
  localparam int QB     = FRAC_BITS + 1;

  logic en;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic        [HEIGHT_W-1:0] height_q;
  logic        [STEP_W-1:0]   step_x_q, step_y_q, dist_q;
  logic signed [CORNER_W-1:0] corner_x_q, corner_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q   <= HEIGHT_W'(1);
      step_x_q   <= STEP_W'(65536);
      step_y_q   <= STEP_W'(65536);
      corner_x_q <= '0;
      corner_y_q <= '0;
      dist_q     <= STEP_W'(65536);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        REG_IMAGE_HEIGHT:    height_q   <= cfg_data_i[HEIGHT_W-1:0];
        REG_STEP_X:          step_x_q   <= cfg_data_i[STEP_W-1:0];
        REG_STEP_Y:          step_y_q   <= cfg_data_i[STEP_W-1:0];
        REG_CORNER_X:        corner_x_q <= $signed(cfg_data_i[CORNER_W-1:0]);
        REG_CORNER_Y:        corner_y_q <= $signed(cfg_data_i[CORNER_W-1:0]);
        REG_CAMERA_DISTANCE: dist_q     <= cfg_data_i[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline enable: everything moves unless the output word is held
  // --------------------------------------------------------------------------
  logic out_vld_q;
  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  // --------------------------------------------------------------------------
  // Stage 1: flip row, step * (2 * index + 1)
  // --------------------------------------------------------------------------
  logic        [COORD_BITS-1:0] col, row;
  logic signed [FLW-1:0]        flip;
  logic        [OXW-1:0]        odd_x;
  logic signed [OYW-1:0]        odd_y;
  logic        [PXW-1:0]        prod_x_q;
  logic signed [PYW-1:0]        prod_y_q;
  logic                         v1_q;

  assign col   = s_axis_tdata[COORD_BITS-1:0];
  assign row   = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
  assign flip  = $signed({{(FLW-HEIGHT_W){1'b0}}, height_q})
               - $signed({{(FLW-COORD_BITS){1'b0}}, row}) - $signed(FLW'(1));
  assign odd_x = {col, 1'b1};
  assign odd_y = $signed({flip, 1'b1});

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_x_q <= PXW'(step_x_q) * PXW'(odd_x);
      prod_y_q <= $signed({1'b0, step_y_q}) * odd_y;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: add twice the corner, take magnitudes
  // --------------------------------------------------------------------------
  logic signed [VW-1:0] vx, vy;
  logic        [VW-1:0] a2_q, b2_q, c2_q;
  logic                 nx2_q, ny2_q, v2_q;

  assign vx = $signed(VW'(prod_x_q))
            + $signed({{(VW-CORNER_W-1){corner_x_q[CORNER_W-1]}}, corner_x_q, 1'b0});
  assign vy = $signed({{(VW-PYW){prod_y_q[PYW-1]}}, prod_y_q})
            + $signed({{(VW-CORNER_W-1){corner_y_q[CORNER_W-1]}}, corner_y_q, 1'b0});

  always_ff @(posedge clk_i) begin
    if (en) begin
      a2_q  <= vx[VW-1] ? VW'(-vx) : VW'(vx);
      b2_q  <= vy[VW-1] ? VW'(-vy) : VW'(vy);
      c2_q  <= VW'({dist_q, 1'b0});
      nx2_q <= vx[VW-1];
      ny2_q <= vy[VW-1];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: largest magnitude
  // --------------------------------------------------------------------------
  logic [VW-1:0] m3_q, a3_q, b3_q, c3_q;
  logic [VW-1:0] mab;
  logic          nx3_q, ny3_q, v3_q;

  assign mab = (b2_q > a2_q) ? b2_q : a2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      m3_q  <= (c2_q > mab) ? c2_q : mab;
      a3_q  <= a2_q;
      b3_q  <= b2_q;
      c3_q  <= c2_q;
      nx3_q <= nx2_q;
      ny3_q <= ny2_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: leading one per byte group
  // --------------------------------------------------------------------------
  logic [NG*8-1:0] mpad;
  logic [NG-1:0]   gnz, gnz4_q;
  logic [2:0]      gidx   [NG];
  logic [2:0]      gidx4_q [NG];
  logic [VW-1:0]   a4_q, b4_q, c4_q;
  logic            nx4_q, ny4_q, v4_q;

  assign mpad = (NG*8)'(m3_q);

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      gnz[g]  = |mpad[g*8 +: 8];
      gidx[g] = '0;
      for (int j = 0; j < 8; j++) begin
        if (mpad[g*8 + j]) gidx[g] = 3'(j);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      gnz4_q  <= gnz;
      gidx4_q <= gidx;
      a4_q    <= a3_q;
      b4_q    <= b3_q;
      c4_q    <= c3_q;
      nx4_q   <= nx3_q;
      ny4_q   <= ny3_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: msb position and shift toward [2^29, 2^30)
  // --------------------------------------------------------------------------
  logic [PW-1:0] msb, sh5_q;
  logic          rgt5_q;
  logic [VW-1:0] a5_q, b5_q, c5_q;
  side_t         sd5_q;
  logic          v5_q;

  always_comb begin
    msb = '0;
    for (int g = 0; g < NG; g++) begin
      if (gnz4_q[g]) msb = {GW'(g), gidx4_q[g]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rgt5_q     <= msb >= PW'(TARGET);
      sh5_q      <= (msb >= PW'(TARGET)) ? (msb - PW'(TARGET)) : (PW'(TARGET) - msb);
      a5_q       <= a4_q;
      b5_q       <= b4_q;
      c5_q       <= c4_q;
      sd5_q.nx   <= nx4_q;
      sd5_q.ny   <= ny4_q;
      sd5_q.zero <= ~|gnz4_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: common shift of all three magnitudes
  // --------------------------------------------------------------------------
  logic [NORM_W-1:0] a6_q, b6_q, c6_q;
  side_t             sd6_q;
  logic              v6_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      a6_q  <= rgt5_q ? NORM_W'(a5_q >> sh5_q) : NORM_W'(a5_q << sh5_q);
      b6_q  <= rgt5_q ? NORM_W'(b5_q >> sh5_q) : NORM_W'(b5_q << sh5_q);
      c6_q  <= rgt5_q ? NORM_W'(c5_q >> sh5_q) : NORM_W'(c5_q << sh5_q);
      sd6_q <= sd5_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 7: squares
  // --------------------------------------------------------------------------
  logic [2*NORM_W-1:0] sqa7_q, sqb7_q, sqc7_q;
  logic [NORM_W-1:0]   a7_q, b7_q, c7_q;
  side_t               sd7_q;
  logic                v7_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sqa7_q <= (2*NORM_W)'(a6_q) * (2*NORM_W)'(a6_q);
      sqb7_q <= (2*NORM_W)'(b6_q) * (2*NORM_W)'(b6_q);
      sqc7_q <= (2*NORM_W)'(c6_q) * (2*NORM_W)'(c6_q);
      a7_q   <= a6_q;
      b7_q   <= b6_q;
      c7_q   <= c6_q;
      sd7_q  <= sd6_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 8: sum of squares
  // --------------------------------------------------------------------------
  logic [SUM_W-1:0]  sum8_q;
  logic [NORM_W-1:0] a8_q, b8_q, c8_q;
  side_t             sd8_q;
  logic              v8_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sum8_q <= SUM_W'(sqa7_q) + SUM_W'(sqb7_q) + SUM_W'(sqc7_q);
      a8_q   <= a7_q;
      b8_q   <= b7_q;
      c8_q   <= c7_q;
      sd8_q  <= sd7_q;
    end
  end

  // valid chain of the front stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
      v8_q <= v7_q;
    end
  end

  // --------------------------------------------------------------------------
  // Square root of the sum
  // --------------------------------------------------------------------------
  logic              vr;
  logic [ROOT_W-1:0] root;
  logic [TW-1:0]     tag_r;
  logic [NORM_W-1:0] ar, br, cr;
  side_t             sdr;

  prdg_isqrt #(
    .TW (TW)
  ) u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (v8_q),
    .s_i    (sum8_q),
    .tag_i  ({a8_q, b8_q, c8_q, sd8_q}),
    .vld_o  (vr),
    .root_o (root),
    .tag_o  (tag_r)
  );

  assign {ar, br, cr, sdr} = tag_r;

  // --------------------------------------------------------------------------
  // Rounded division of each component by the root
  // --------------------------------------------------------------------------
  logic [FRAC_BITS:0] qx, qy, qz;

  prdg_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
    .clk_i (clk_i), .en_i (en), .a_i (ar), .r_i (root), .q_o (qx)
  );
  prdg_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
    .clk_i (clk_i), .en_i (en), .a_i (br), .r_i (root), .q_o (qy)
  );
  prdg_div #(.FRAC_BITS(FRAC_BITS)) u_div_z (
    .clk_i (clk_i), .en_i (en), .a_i (cr), .r_i (root), .q_o (qz)
  );

  // flags and valid keep pace with the dividers
  logic [QB-1:0] dv_q;
  side_t         ds_q [QB];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q <= '0;
    end else if (en) begin
      dv_q <= {dv_q[QB-2:0], vr};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ds_q[0] <= sdr;
      for (int i = 1; i < QB; i++) ds_q[i] <= ds_q[i-1];
    end
  end

  // --------------------------------------------------------------------------
  // Output register: signs and the zero vector
  // --------------------------------------------------------------------------
  side_t            sdo;
  logic [XY_W-1:0]  out_x_q, out_y_q;
  logic [Z_W-1:0]   out_z_q;

  assign sdo = ds_q[QB-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dv_q[QB-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (sdo.zero) begin
        out_x_q <= '0;
        out_y_q <= '0;
        out_z_q <= '0;
      end else begin
        out_x_q <= sdo.nx ? XY_W'(-XY_W'(qx)) : XY_W'(qx);
        out_y_q <= sdo.ny ? XY_W'(-XY_W'(qy)) : XY_W'(qy);
        out_z_q <= qz;
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OUT_W'({out_z_q, out_y_q, out_x_q});

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  localparam logic signed [XY_W-1:0] ONE_S = XY_W'(1) << FRAC_BITS;

  a_z_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> out_z_q <= Z_W'(ONE_S))
    else $error("dir_z above one");

  a_x_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> ($signed(out_x_q) <= ONE_S) && ($signed(out_x_q) >= -ONE_S))
    else $error("dir_x outside unit range");

  a_y_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> ($signed(out_y_q) <= ONE_S) && ($signed(out_y_q) >= -ONE_S))
    else $error("dir_y outside unit range");

  a_root_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(root) && $stable(qx) && $stable(dv_q))
    else $error("pipeline moved during stall");

endmodule : pinhole_ray_direction_generator
`default_nettype wire

### dv/pinhole_ray_direction_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pinhole_ray_direction_checker
// Watches the pixel and direction streams and the config port, predicts the
// unit ray direction of every accepted pixel and compares it field by field.
// ----------------------------------------------------------------------------
module pinhole_ray_direction_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [55:0] m_axis_tdata,
  output int               fail_count_o,
  output int               pending_o
);
  import prdg_pkg::*;

  localparam int FRAC = 16;

  typedef struct packed {
    logic [16:0] dz;
    logic [17:0] dy;
    logic [17:0] dx;
  } dir_t;

  // shadow copy of the camera registers
  logic [12:0]        height_q;
  logic [30:0]        step_x_q, step_y_q, dist_q;
  logic signed [31:0] corner_x_q, corner_y_q;

  dir_t dir_queue[$];

  function automatic logic [63:0] int_sqrt(logic [63:0] s);
    logic [63:0] root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv >>= 2;
    while (bitv != 0) begin
      if (s >= root + bitv) begin
        s = s - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic dir_t ray_direction(logic [11:0] col, logic [11:0] row);
    longint flipped, vx, vy, vz;
    logic [63:0] a, b, c, m, r, qx, qy, qz;
    dir_t d;
    flipped = longint'(height_q) - 1 - longint'(row);
    vx = 2 * longint'(corner_x_q) + longint'(step_x_q) * (2 * longint'(col) + 1);
    vy = 2 * longint'(corner_y_q) + longint'(step_y_q) * (2 * flipped + 1);
    vz = 2 * longint'(dist_q);
    a = vx < 0 ? -vx : vx;
    b = vy < 0 ? -vy : vy;
    c = vz;
    m = a;
    if (b > m) m = b;
    if (c > m) m = c;
    if (m == 0) return '0;
    while (m >= (64'd1 << 30)) begin
      m >>= 1; a >>= 1; b >>= 1; c >>= 1;
    end
    while (m < (64'd1 << 29)) begin
      m <<= 1; a <<= 1; b <<= 1; c <<= 1;
    end
    r  = int_sqrt(a * a + b * b + c * c);
    qx = ((a << (FRAC + 1)) + r) / (2 * r);
    qy = ((b << (FRAC + 1)) + r) / (2 * r);
    qz = ((c << (FRAC + 1)) + r) / (2 * r);
    if (vx < 0) qx = -qx;
    if (vy < 0) qy = -qy;
    d.dx = qx[17:0];
    d.dy = qy[17:0];
    d.dz = qz[16:0];
    return d;
  endfunction

  assign pending_o = dir_queue.size();

  always @(posedge clk_i or negedge rst_ni) begin
    dir_t got, want;
    if (!rst_ni) begin
      height_q     <= 13'd1;
      step_x_q     <= 31'd65536;
      step_y_q     <= 31'd65536;
      dist_q       <= 31'd65536;
      corner_x_q   <= '0;
      corner_y_q   <= '0;
      fail_count_o <= 0;
      dir_queue.delete();
    end else begin
      // config writes land at the same edge as in the block
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          REG_IMAGE_HEIGHT:    height_q   <= cfg_data_i[12:0];
          REG_STEP_X:          step_x_q   <= cfg_data_i[30:0];
          REG_STEP_Y:          step_y_q   <= cfg_data_i[30:0];
          REG_CORNER_X:        corner_x_q <= cfg_data_i;
          REG_CORNER_Y:        corner_y_q <= cfg_data_i;
          REG_CAMERA_DISTANCE: dist_q     <= cfg_data_i[30:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        dir_queue.push_back(ray_direction(s_axis_tdata[11:0], s_axis_tdata[23:12]));
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[52:0];
        if (dir_queue.size() == 0) begin
          $display("%0t: unexpected word, actual %h", $time, got);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = dir_queue.pop_front();
          if (got.dx !== want.dx || got.dy !== want.dy || got.dz !== want.dz) begin
            $display("%0t: mismatch, expected x=%h y=%h z=%h, actual x=%h y=%h z=%h",
                     $time, want.dx, want.dy, want.dz, got.dx, got.dy, got.dz);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end
endmodule

### dv/pinhole_ray_direction_generator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pinhole_ray_direction_generator_tb
// Drives pixels through several camera set-ups with random gaps and output
// stalls; the checker predicts every direction word and counts mismatches.
// ----------------------------------------------------------------------------
module pinhole_ray_direction_generator_tb;
  import prdg_pkg::*;

  localparam int LATENCY = 57;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  int          fail_count, pending;
  bit          stall_on = 1'b1;

  always #2 clk_i = ~clk_i;

  pinhole_ray_direction_generator dut (.*);
  pinhole_ray_direction_checker chk (.*, .fail_count_o(fail_count), .pending_o(pending));

  // output side: random stalls per word
  initial begin
    int w;
    forever begin
      w = stall_on ? $urandom_range(0, 5) : 0;
      if (w > 0) begin
        m_axis_tready <= 1'b0;
        repeat (w) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  // one register write per cycle; the caller drops the enable afterwards
  task automatic write_reg(cfg_idx_e idx, logic [31:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
  endtask

  task automatic send_pixel(logic [11:0] col, logic [11:0] row, bit gaps);
    int g;
    g = gaps ? $urandom_range(0, 5) : 0;
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {row, col};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic drain_pipe;
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  task automatic camera_setup(logic [12:0] h, logic [30:0] sx, logic [30:0] sy,
                              logic [31:0] cx, logic [31:0] cy, logic [30:0] d);
    write_reg(REG_IMAGE_HEIGHT, 32'(h));
    write_reg(REG_STEP_X, 32'(sx));
    write_reg(REG_STEP_Y, 32'(sy));
    write_reg(REG_CORNER_X, cx);
    write_reg(REG_CORNER_Y, cy);
    write_reg(REG_CAMERA_DISTANCE, 32'(d));
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset set-up, field extremes
    send_pixel(12'd0, 12'd0, 0);
    send_pixel(12'hFFF, 12'hFFF, 0);
    send_pixel(12'hFFF, 12'd0, 0);
    send_pixel(12'd0, 12'hFFF, 0);
    drain_pipe();
    // zero vector, then zero height with row flip going negative
    camera_setup(13'd0, 31'd0, 31'd0, 32'd0, 32'd0, 31'd0);
    send_pixel(12'd0, 12'd0, 0);
    drain_pipe();
    camera_setup(13'd0, 31'h7FFFFFFF, 31'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                 31'h7FFFFFFF);
    send_pixel(12'd0, 12'd0, 0);
    send_pixel(12'hFFF, 12'hFFF, 0);
    send_pixel(12'h555, 12'hAAA, 0);
    drain_pipe();
    camera_setup(13'h1FFF, 31'd1, 31'd1, 32'h7FFFFFFF, 32'h80000000, 31'd1);
    send_pixel(12'hAAA, 12'h555, 0);
    send_pixel(12'hFFF, 12'd0, 0);
    drain_pipe();

    // random phases: a typical camera, then random registers
    for (int ph = 0; ph < 9; ph++) begin
      logic [12:0] h;
      h = (ph == 0) ? 13'd4096 : 13'($urandom_range(1, 4096));
      if (ph < 5)
        camera_setup(h, 31'($urandom_range(1, 2000)), 31'($urandom_range(1, 2000)),
                     -32'($urandom_range(0, 1 << 22)), -32'($urandom_range(0, 1 << 22)),
                     31'($urandom_range(1, 1 << 18)));
      else
        camera_setup(13'($urandom), 31'($urandom), 31'($urandom), $urandom, $urandom,
                     31'($urandom));
      stall_on = (ph != 3);
      for (int i = 0; i < 200; i++) begin
        logic [11:0] row;
        row = ($urandom_range(0, 9) == 0 || h == 0) ? 12'($urandom)
                                                    : 12'($urandom_range(0, h - 1));
        send_pixel(12'($urandom), row, ph != 3 && $urandom_range(0, 3) != 0);
        if (i == 100) drain_pipe();
      end
      drain_pipe();
    end
    stall_on = 1'b1;

    if (fail_count == 0)
      $display("pinhole_ray_direction_generator test passed");
    else
      $display("pinhole_ray_direction_generator test failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("pinhole_ray_direction_generator test failed");
    $finish;
  end
endmodule
